FILE: rtl/core/stack_with_scalar_ops_unit_assert.svh
// Assertion macros used by the checker of the stack unit.
`ifndef STACK_WITH_SCALAR_OPS_UNIT_ASSERT_SVH
`define STACK_WITH_SCALAR_OPS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define SSO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define SSO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sso_pkg.sv
// Shared types, codes and a helper function for the stack unit.
`timescale 1ns / 1ps

package sso_pkg;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int BIT_CNT_W = $clog2(WORD_W);

    // Operation codes of an input transaction.
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_POP  = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd5;

    // Status codes of a result transaction.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd3;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctrl_t;

    function automatic alu_op_t op_to_alu(input logic [OP_W-1:0] op);
        alu_op_t res;
        case (op)
            OP_SUB:  res = ALU_SUB;
            OP_MUL:  res = ALU_MUL;
            OP_DIV:  res = ALU_DIV;
            default: res = ALU_ADD;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/core/sso_serial_alu.sv
// Bit-serial arithmetic unit: add, subtract, multiply and divide one entry by a scalar.
`timescale 1ns / 1ps

module sso_serial_alu (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sso_pkg::alu_ctrl_t         ctrl,
    input  logic [sso_pkg::WORD_W-1:0] entry,
    input  logic [sso_pkg::WORD_W-1:0] scalar,
    output logic                       done,
    output logic [sso_pkg::WORD_W-1:0] result
);
    import sso_pkg::*;

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_PREP = 4'b0010,
        A_RUN  = 4'b0100,
        A_FIX  = 4'b1000
    } alu_state_t;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(WORD_W - 1);

    alu_state_t           state_reg,  state_next;
    alu_op_t              op_reg,     op_next;
    logic [WORD_W-1:0]    a_reg,      a_next;
    logic [WORD_W-1:0]    b_reg,      b_next;
    logic [WORD_W-1:0]    acc_reg,    acc_next;
    logic                 carry_reg,  carry_next;
    logic                 neg_reg,    neg_next;
    logic [BIT_CNT_W-1:0] cnt_reg,    cnt_next;
    logic [WORD_W-1:0]    result_reg, result_next;
    logic                 done_reg,   done_next;

    logic              sum_bit;
    logic [WORD_W:0]   shifted;
    logic [WORD_W+1:0] trial;
    logic              borrow;

    assign sum_bit = a_reg[0] ^ b_reg[0] ^ carry_reg;
    // Restoring division step: remainder shifted left, next dividend bit brought in.
    assign shifted = {acc_reg, a_reg[WORD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, b_reg};
    assign borrow  = trial[WORD_W+1];

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        carry_next  = carry_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        done_next   = 1'b0;

        unique case (state_reg)
            A_IDLE:
            begin
                if (ctrl.start)
                begin
                    a_next     = entry;
                    b_next     = scalar;
                    op_next    = ctrl.op;
                    state_next = A_PREP;
                end
            end
            A_PREP:
            begin
                acc_next   = '0;
                cnt_next   = '0;
                neg_next   = a_reg[WORD_W-1] ^ b_reg[WORD_W-1];
                carry_next = (op_reg == ALU_SUB);
                case (op_reg)
                    ALU_SUB:
                    begin
                        b_next = ~b_reg;
                    end
                    ALU_DIV:
                    begin
                        a_next = a_reg[WORD_W-1] ? (~a_reg + WORD_W'(1)) : a_reg;
                        b_next = b_reg[WORD_W-1] ? (~b_reg + WORD_W'(1)) : b_reg;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = A_RUN;
            end
            A_RUN:
            begin
                case (op_reg)
                    ALU_MUL:
                    begin
                        acc_next = b_reg[0] ? (acc_reg + a_reg) : acc_reg;
                        a_next   = {a_reg[WORD_W-2:0], 1'b0};
                        b_next   = {1'b0, b_reg[WORD_W-1:1]};
                    end
                    ALU_DIV:
                    begin
                        acc_next = borrow ? shifted[WORD_W-1:0] : trial[WORD_W-1:0];
                        a_next   = {a_reg[WORD_W-2:0], ~borrow};
                    end
                    default:
                    begin
                        acc_next   = {sum_bit, acc_reg[WORD_W-1:1]};
                        carry_next = (a_reg[0] & b_reg[0]) | (carry_reg & (a_reg[0] ^ b_reg[0]));
                        a_next     = {1'b0, a_reg[WORD_W-1:1]};
                        b_next     = {1'b0, b_reg[WORD_W-1:1]};
                    end
                endcase
                cnt_next = cnt_reg + BIT_CNT_W'(1);
                if (cnt_reg == LAST_BIT)
                begin
                    state_next = A_FIX;
                end
            end
            A_FIX:
            begin
                if (op_reg == ALU_DIV)
                begin
                    result_next = neg_reg ? (~a_reg + WORD_W'(1)) : a_reg;
                end
                else
                begin
                    result_next = acc_reg;
                end
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        carry_reg  <= carry_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: rtl/core/stack_with_scalar_ops_unit.sv
// Top level of the stack unit: entry memory, sequencer and result register.
// Push, rejected requests and unused codes give their result in the cycle after acceptance.
// Pop reads the memory, stages the entry in S_POP, then loads it from S_FINISH once the slot is free.
// A broadcast operation over n entries reads each entry, passes it through the bit-serial
// unit (one bit per cycle) and writes it back in turn.
// One transaction is in flight at a time; reset clears the depth and the control state only.
`timescale 1ns / 1ps

module stack_with_scalar_ops_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [sso_pkg::OP_W-1:0]              operation,
    input  logic signed [sso_pkg::WORD_W-1:0]     operand,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [sso_pkg::WORD_W-1:0]     popped_value,
    output logic [sso_pkg::STATUS_W-1:0]          status,
    output logic [$clog2(STACK_DEPTH+1)-1:0]      depth
);
    import sso_pkg::*;

    // The address width indexes the entry memory; the count width can also hold a full stack.
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    // Sequencer states. A pop waits in S_POP for the memory read; a broadcast walks the
    // entries from the bottom of the stack upwards, one entry through the serial unit at a time.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_POP    = 6'b000010,
        S_READ   = 6'b000100,
        S_LOAD   = 6'b001000,
        S_CALC   = 6'b010000,
        S_FINISH = 6'b100000
    } seq_state_t;

    seq_state_t        state_reg,  state_next;
    logic [CW-1:0]     count_reg,  count_next;
    logic [AW-1:0]     idx_reg,    idx_next;
    alu_op_t           op_reg,     op_next;
    logic [WORD_W-1:0] scalar_reg, scalar_next;
    logic [WORD_W-1:0] pend_reg,   pend_next;

    // Result register, which decouples the sequencer from the consumer.
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   popped_reg,    popped_next;
    logic [STATUS_W-1:0] status_reg,    status_next;
    logic [CW-1:0]       depth_reg,     depth_next;

    // Entry memory: one write port and one registered read port.
    logic [WORD_W-1:0] mem [STACK_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    logic              accept;
    logic              out_free;
    logic              load_out;
    logic [WORD_W-1:0] load_popped;
    logic [STATUS_W-1:0] load_status;
    logic [CW-1:0]     count_dec;
    logic [CW-1:0]     idx_ext;

    alu_ctrl_t         alu_ctrl;
    logic              alu_done;
    logic [WORD_W-1:0] alu_result;

    // The result slot is free when empty or when its transaction leaves in this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign accept    = in_valid && !in_stall;
    assign count_dec = count_reg - CW'(1);
    assign idx_ext   = CW'(idx_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        op_next      = op_reg;
        scalar_next  = scalar_reg;
        pend_next    = pend_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = alu_result;
        mem_re       = 1'b0;
        mem_raddr    = idx_reg;
        load_out     = 1'b0;
        load_popped  = '0;
        load_status  = ST_OK;
        alu_ctrl.start = 1'b0;
        alu_ctrl.op    = op_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation) inside
                        OP_PUSH:
                        begin
                            load_out = 1'b1;
                            if (count_reg == FULL_COUNT)
                            begin
                                load_status = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = operand;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                load_out    = 1'b1;
                                load_status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = count_dec[AW-1:0];
                                count_next = count_dec;
                                state_next = S_POP;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                        begin
                            // A zero divisor is refused even on an empty stack.
                            if ((operation == OP_DIV) && (operand == '0))
                            begin
                                load_out    = 1'b1;
                                load_status = ST_DIV_ZERO;
                            end
                            else if (count_reg == '0)
                            begin
                                load_out = 1'b1;
                            end
                            else
                            begin
                                op_next     = op_to_alu(operation);
                                scalar_next = operand;
                                pend_next   = '0;
                                idx_next    = '0;
                                state_next  = S_READ;
                            end
                        end
                        default:
                        begin
                            // Unused operation codes leave the stack untouched.
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                pend_next  = rd_data_reg;
                state_next = S_FINISH;
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                alu_ctrl.start = 1'b1;
                state_next     = S_CALC;
            end
            S_CALC:
            begin
                if (alu_done)
                begin
                    mem_we = 1'b1;
                    if ((idx_ext + CW'(1)) == count_reg)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    load_out    = 1'b1;
                    load_popped = pend_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        popped_next    = popped_reg;
        status_next    = status_reg;
        depth_next     = depth_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            popped_next    = load_popped;
            status_next    = load_status;
            depth_next     = count_next;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        scalar_reg <= scalar_next;
        pend_reg   <= pend_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
        depth_reg  <= depth_next;
    end

    // Entries above the depth are never read, so the memory needs no reset.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    sso_serial_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (alu_ctrl),
        .entry  (rd_data_reg),
        .scalar (scalar_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign depth        = depth_reg;

endmodule

FILE: rtl/core/sso_checker.sv
// Port-level checker for the stack unit and its bind to the top level.
`timescale 1ns / 1ps
`include "stack_with_scalar_ops_unit_assert.svh"

module sso_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic [sso_pkg::WORD_W-1:0]            popped_value,
    input  logic [sso_pkg::STATUS_W-1:0]          status,
    input  logic [$clog2(STACK_DEPTH+1)-1:0]      depth
);
    import sso_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);

    `SSO_ASSERT_NOW(a_depth_bound, out_valid, depth <= DW'(STACK_DEPTH), "depth beyond capacity")
    `SSO_ASSERT_NOW(a_full_depth, out_valid && (status == ST_FULL), depth == DW'(STACK_DEPTH), "full flagged below capacity")
    `SSO_ASSERT_NOW(a_empty_pop, out_valid && (status == ST_EMPTY), (depth == '0) && (popped_value == '0), "empty pop with data or depth")
    `SSO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(popped_value) && $stable(status) && $stable(depth), "stalled result changed")

endmodule

bind stack_with_scalar_ops_unit sso_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sso_checker (.*);
